// ===== sv/lsh_pkg.sv =====
// ----------------------------------------------------------------------------
// lsh_pkg : shared constants and types for the 3x3 Laplacian sharpener
// Frame limits, field widths, register indexes, neighbour mask and line-pair types.
// ----------------------------------------------------------------------------
package lsh_pkg;

  localparam int unsigned MaxCols = 1024;
  localparam int unsigned MaxRows = 1024;

  localparam int unsigned ColW    = $clog2(MaxCols);
  localparam int unsigned RowW    = $clog2(MaxRows);
  localparam int unsigned DimW    = 11;
  localparam int unsigned PixW    = 8;
  localparam int unsigned ResW    = 13;
  localparam int unsigned NsumW   = PixW + 3;
  localparam int unsigned CfgIdxW = 4;

  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegFrameHeight = CfgIdxW'(1);

  // which neighbour rows and columns lie inside the frame
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } nbr_mask_t;

  // one column of each line store
  typedef struct packed {
    logic [PixW-1:0] one_up;
    logic [PixW-1:0] two_up;
  } line_pair_t;

  // zero reads as one, above the maximum reads as the maximum
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                               input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// ===== sv/lsh_line_store.sv =====
// ----------------------------------------------------------------------------
// lsh_line_store : paired line stores, one column per entry
// Single write and single registered read; a read of the address written in
// the same cycle returns the new data.
// ----------------------------------------------------------------------------
module lsh_line_store (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [lsh_pkg::ColW-1:0] rd_addr_i,
  output lsh_pkg::line_pair_t      rd_data_o,
  input  logic                     wr_en_i,
  input  logic [lsh_pkg::ColW-1:0] wr_addr_i,
  input  lsh_pkg::line_pair_t      wr_data_i
);
  import lsh_pkg::*;

  line_pair_t mem_q [MaxCols];
  line_pair_t rd_q;
  line_pair_t fwd_data_q;
  logic       fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== sv/lsh_kernel.sv =====
// ----------------------------------------------------------------------------
// lsh_kernel : 3x3 window and sharpening sum
// Shifts a new column in on each step; result is 9*centre less the in-frame
// neighbours of the window after the shift.
// ----------------------------------------------------------------------------
module lsh_kernel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [lsh_pkg::PixW-1:0]      top_i,
  input  logic [lsh_pkg::PixW-1:0]      mid_i,
  input  logic [lsh_pkg::PixW-1:0]      bot_i,
  input  lsh_pkg::nbr_mask_t            mask_i,
  output logic signed [lsh_pkg::ResW-1:0] sharpened_o
);
  import lsh_pkg::*;

  // held columns: [row] of the two most recent columns
  logic [PixW-1:0] col_a_q [3];
  logic [PixW-1:0] col_b_q [3];
  logic [PixW-1:0] w0 [3];
  logic [PixW-1:0] w1 [3];
  logic [PixW-1:0] w2 [3];
  logic [NsumW-1:0]  nsum;
  logic [PixW+3:0]   centre9;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        col_a_q[r] <= '0;
        col_b_q[r] <= '0;
      end
    end else if (step_i) begin
      for (int r = 0; r < 3; r++) begin
        col_a_q[r] <= col_b_q[r];
      end
      col_b_q[0] <= top_i;
      col_b_q[1] <= mid_i;
      col_b_q[2] <= bot_i;
    end
  end

  // window after this step
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      w0[r] = col_a_q[r];
      w1[r] = col_b_q[r];
    end
    w2[0] = top_i;
    w2[1] = mid_i;
    w2[2] = bot_i;
  end

  always_comb begin
    nsum = '0;
    if (mask_i.up) begin
      nsum = nsum + NsumW'(w1[0]);
      if (mask_i.left)  nsum = nsum + NsumW'(w0[0]);
      if (mask_i.right) nsum = nsum + NsumW'(w2[0]);
    end
    if (mask_i.down) begin
      nsum = nsum + NsumW'(w1[2]);
      if (mask_i.left)  nsum = nsum + NsumW'(w0[2]);
      if (mask_i.right) nsum = nsum + NsumW'(w2[2]);
    end
    if (mask_i.left)  nsum = nsum + NsumW'(w0[1]);
    if (mask_i.right) nsum = nsum + NsumW'(w2[1]);
    centre9 = {w1[1], 3'b000} + (PixW+4)'(w1[1]);
  end

  assign sharpened_o = $signed(ResW'(centre9)) - $signed(ResW'(nsum));

endmodule

// ===== sv/laplacian_sharpen_3x3.sv =====
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3 : streaming 3x3 Laplacian sharpening filter
// Raster-order 8-bit pixels in, 9*centre minus neighbour sum out.
// ----------------------------------------------------------------------------
// Usage notes:
//  - s_axis carries one pixel per request; tuser set means a flush request
//    (no pixel, counts as zero). m_axis carries one signed result per
//    request, tlast marks the last result of the frame.
//  - Results trail the input by one row and one column: the first
//    frame_width+1 requests of a frame give nothing, and after the last
//    pixel the host sends frame_width+1 flush requests to drain.
//  - Pipeline: input stage (counters, line-store read) -> window stage
//    (line-store write, kernel sum) -> output register.
//  - Throughput: one request per clock unless m_axis stalls, set by the single
//    line-store port pair (one read, one write per cycle); back-to-back
//    columns at the same address (width 1) are forwarded inside the store.
//  - A stalled receiver holds the output register; the window stage and
//    then s_axis_tready follow, so nothing is dropped.
//  - Reset: width 640, height 480, window zero, frame start. Line stores
//    are not cleared; out-of-frame taps are masked so stale data is unseen.
//  - Configuration writes (index 0 width, 1 height) restart the frame; host must
//    send them only with the stream idle; not enforced, cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lsh_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lsh_pkg::DimW-1:0]    cfg_data_i,
  // pixel stream in
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] pixel
  input  logic                        s_axis_tuser,   // [0] flush
  // result stream out
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,   // [12:0] sharpened, [15:13] zero
  output logic                        m_axis_tlast    // frame_end
);
  import lsh_pkg::*;

  // --- configuration -------------------------------------------------------
  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic            cfg_wr;
  logic            restart;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    restart  = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_index_i)
        RegFrameWidth: begin
          width_d = clamp_dim(cfg_data_i, DimW'(MaxCols));
          restart = 1'b1;
        end
        RegFrameHeight: begin
          height_d = clamp_dim(cfg_data_i, DimW'(MaxRows));
          restart  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // --- input stage: positions and flags -----------------------------------
  logic            in_acc;
  logic [ColW-1:0] in_col_q, in_col_d;
  logic [1:0]      in_row_q, in_row_d;   // saturates at 2
  logic [ColW-1:0] out_col_q, out_col_d;
  logic [RowW-1:0] out_row_q, out_row_d;
  logic            primed;
  logic            in_wrap;
  nbr_mask_t       mask;
  logic            last;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign primed  = (in_row_q == 2'd2) || ((in_row_q == 2'd1) && (in_col_q != '0));
  assign in_wrap = (DimW'(in_col_q) + DimW'(1)) >= width_q;

  assign mask.up    = (out_row_q != '0);
  assign mask.down  = (DimW'(out_row_q) + DimW'(1)) < height_q;
  assign mask.left  = (out_col_q != '0);
  assign mask.right = (DimW'(out_col_q) + DimW'(1)) < width_q;
  assign last       = !mask.down && !mask.right;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (in_acc) begin
      if (in_wrap) begin
        in_col_d = '0;
        if (in_row_q != 2'd2) in_row_d = in_row_q + 2'd1;
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
      if (primed) begin
        if (!mask.right) begin
          out_col_d = '0;
          out_row_d = out_row_q + RowW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
      // last result of the frame: start over
      if (primed && last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end
    end
    if (restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WidthReset;
      height_q  <= HeightReset;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // --- window stage --------------------------------------------------------
  logic            b_valid_q;
  logic            b_primed_q;
  logic            b_last_q;
  nbr_mask_t       b_mask_q;
  logic [PixW-1:0] b_pix_q;
  logic [ColW-1:0] b_col_q;
  logic            b_adv;
  line_pair_t      rd_pair;
  line_pair_t      wr_pair;
  logic signed [ResW-1:0] sharpened;

  assign b_adv         = b_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !b_valid_q || b_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      b_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_primed_q <= primed;
      b_last_q   <= last;
      b_mask_q   <= mask;
      b_pix_q    <= s_axis_tuser ? '0 : s_axis_tdata[PixW-1:0];
      b_col_q    <= in_col_q;
    end
  end

  // column shifts down one line store on its way through
  assign wr_pair.one_up = b_pix_q;
  assign wr_pair.two_up = rd_pair.one_up;

  lsh_line_store u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_col_q),
    .rd_data_o (rd_pair),
    .wr_en_i   (b_adv),
    .wr_addr_i (b_col_q),
    .wr_data_i (wr_pair)
  );

  lsh_kernel u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (b_adv),
    .top_i       (rd_pair.two_up),
    .mid_i       (rd_pair.one_up),
    .bot_i       (b_pix_q),
    .mask_i      (b_mask_q),
    .sharpened_o (sharpened)
  );

  // --- output register -----------------------------------------------------
  logic            out_valid_q;
  logic [ResW-1:0] out_data_q;
  logic            out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_adv) begin
      out_valid_q <= b_primed_q;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && b_primed_q) begin
      out_data_q <= sharpened;
      out_last_q <= b_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(16 - ResW)'(0), out_data_q};
  assign m_axis_tlast  = out_last_q;

endmodule
